### hdl/nvm_pkg.sv
// nvm_pkg: types, status codes and state encoding for the nearest value match unit
// no dependencies
package nvm_pkg;

    localparam int PoolDepthDefault = 1024;

    typedef enum logic [1:0] {
        ST_LOADED  = 2'd0,
        ST_MATCHED = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  matched_index;
        logic [31:0] abs_diff;
        logic [31:0] peak_diff;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DECIDE,
        S_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_start;
        logic scan_step;
        logic shift_start;
        logic shift_step;
        logic load_write;
        logic match_commit;
        logic empty_result;
        logic full_result;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_query;
        logic pool_full;
        logic scan_done;
        logic shift_done;
    } dp_stat_t;

endpackage

### hdl/nvm_ctrl.sv
// nvm_ctrl: sequencer for load insertion and query scan
// depends on nvm_pkg
module nvm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output nvm_pkg::dp_cmd_t cmd,
    input  nvm_pkg::dp_stat_t stat
);
    import nvm_pkg::*;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid) state_next = S_DECIDE;
            S_DECIDE:
                if (!stat.is_query)
                    state_next = stat.pool_full ? S_RESULT : S_SCAN;
                else
                    state_next = S_SCAN;
            S_SCAN:
                if (stat.scan_done) state_next = stat.is_query ? S_RESULT : S_SHIFT;
            S_SHIFT:
                if (stat.shift_done) state_next = S_RESULT;
            S_RESULT:
                if (out_ready) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = (state_reg == S_IDLE);
        out_valid = (state_reg == S_RESULT);
        case (state_reg)
            S_IDLE:
                cmd.capture = in_valid;
            S_DECIDE:
                if (!stat.is_query && stat.pool_full) cmd.full_result = 1'b1;
                else cmd.scan_start = 1'b1;
            S_SCAN:
            begin
                cmd.scan_step = !stat.scan_done;
                if (stat.scan_done && !stat.is_query) cmd.shift_start = 1'b1;
                if (stat.scan_done && stat.is_query) cmd.match_commit = 1'b1;
            end
            S_SHIFT:
            begin
                cmd.shift_step = !stat.shift_done;
                cmd.load_write = stat.shift_done;
            end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) != S_IDLE) else $error("result without work");
    a_scan_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> state_reg == S_DECIDE)
        else $error("accepted item not started");

endmodule

### hdl/nvm_dpath.sv
// nvm_dpath: pool memories, scan pointer, insertion shifter and match arithmetic
// depends on nvm_pkg
module nvm_dpath #(
    parameter int POOL_DEPTH = nvm_pkg::PoolDepthDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  nvm_pkg::in_item_t  in_item,
    input  nvm_pkg::dp_cmd_t   cmd,
    output nvm_pkg::dp_stat_t  stat,
    output nvm_pkg::out_item_t out_item
);
    import nvm_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int IW = AW > 10 ? AW : 10;

    // pool storage: one combined word per slot {live, index, value}
    logic [32+IW:0] pool_mem [POOL_DEPTH];
    logic [32+IW:0] rd_data_reg;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [32+IW:0] wr_data;

    // epoch-style live: live bit only trusted below count, slots below count written
    logic [CW-1:0]  count_reg;
    logic [31:0]    max_reg;
    logic           query_reg;
    logic [31:0]    q_reg;

    // scan state
    logic [CW-1:0]  ptr_reg;
    logic           rd_pending_reg;
    logic           have_lo_reg, have_hi_reg, stop_reg;
    logic [AW-1:0]  lo_addr_reg, hi_addr_reg;
    logic [31:0]    lo_val_reg, hi_val_reg;
    logic [IW-1:0]  lo_idx_reg, hi_idx_reg;
    logic [CW-1:0]  pos_reg;
    logic           scan_done;

    // shift state
    logic [CW-1:0]  sh_reg;
    logic           sh_rd_reg;
    logic           shift_done;
    out_item_t      out_reg;

    logic           r_live;
    logic [IW-1:0]  r_idx;
    logic [31:0]    r_val;
    assign {r_live, r_idx, r_val} = rd_data_reg;

    assign scan_done  = stop_reg || (ptr_reg == count_reg && !rd_pending_reg);
    assign shift_done = (sh_reg == pos_reg) && !sh_rd_reg;

    assign stat.is_query   = query_reg;
    assign stat.pool_full  = (count_reg == CW'(POOL_DEPTH));
    assign stat.scan_done  = scan_done;
    assign stat.shift_done = shift_done;
    assign out_item        = out_reg;

    // read address: scan pointer or shift source, one slot ahead of the write
    always_comb
    begin
        if (cmd.shift_step || cmd.shift_start) rd_addr = AW'(sh_reg - CW'(2));
        else rd_addr = ptr_reg[AW-1:0];
        if (cmd.shift_start) rd_addr = AW'(count_reg - CW'(1));
    end

    // write port: shift moves, insert, or clear live on match
    logic lo_wins;
    logic [31:0] d_lo, d_hi;
    assign d_lo = q_reg - lo_val_reg;
    assign d_hi = hi_val_reg - q_reg;
    assign lo_wins = have_lo_reg && (!have_hi_reg || d_lo < d_hi);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (cmd.shift_step && sh_rd_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = sh_reg[AW-1:0];
            wr_data = rd_data_reg;
        end
        else if (cmd.load_write)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[AW-1:0];
            wr_data = {1'b1, IW'(count_reg), q_reg};
        end
        else if (cmd.match_commit && (have_lo_reg || have_hi_reg))
        begin
            wr_en   = 1'b1;
            wr_addr = lo_wins ? lo_addr_reg : hi_addr_reg;
            wr_data = lo_wins ? {1'b0, lo_idx_reg, lo_val_reg}
                              : {1'b0, hi_idx_reg, hi_val_reg};
        end
    end

    // memory
    always_ff @(posedge clk)
    begin
        if (wr_en) pool_mem[wr_addr] <= wr_data;
        rd_data_reg <= pool_mem[rd_addr];
    end

    // scan control and result
    logic [31:0] win_diff;
    assign win_diff = lo_wins ? d_lo : d_hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            max_reg        <= '0;
            query_reg      <= 1'b0;
            ptr_reg        <= '0;
            rd_pending_reg <= 1'b0;
            stop_reg       <= 1'b0;
            have_lo_reg    <= 1'b0;
            have_hi_reg    <= 1'b0;
            sh_reg         <= '0;
            sh_rd_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                query_reg <= in_item.cmd;
                q_reg     <= in_item.value;
            end
            if (cmd.scan_start)
            begin
                ptr_reg        <= '0;
                rd_pending_reg <= 1'b0;
                stop_reg       <= 1'b0;
                have_lo_reg    <= 1'b0;
                have_hi_reg    <= 1'b0;
                pos_reg        <= count_reg;
            end
            else if (cmd.scan_step)
            begin
                // evaluate the slot read last cycle
                if (rd_pending_reg)
                begin
                    if (!query_reg)
                    begin
                        if (r_val > q_reg)
                        begin
                            pos_reg  <= ptr_reg - CW'(1);
                            stop_reg <= 1'b1;
                        end
                    end
                    else if (r_live)
                    begin
                        if (r_val < q_reg)
                        begin
                            have_lo_reg <= 1'b1;
                            lo_addr_reg <= AW'(ptr_reg - CW'(1));
                            lo_val_reg  <= r_val;
                            lo_idx_reg  <= r_idx;
                        end
                        else
                        begin
                            have_hi_reg <= 1'b1;
                            hi_addr_reg <= AW'(ptr_reg - CW'(1));
                            hi_val_reg  <= r_val;
                            hi_idx_reg  <= r_idx;
                            stop_reg    <= 1'b1;
                        end
                    end
                end
                if (ptr_reg != count_reg)
                begin
                    ptr_reg        <= ptr_reg + CW'(1);
                    rd_pending_reg <= 1'b1;
                end
                else rd_pending_reg <= 1'b0;
            end
            if (cmd.shift_start)
            begin
                sh_reg    <= count_reg;
                sh_rd_reg <= (count_reg != pos_reg);
            end
            else if (cmd.shift_step)
            begin
                if (sh_rd_reg) sh_reg <= sh_reg - CW'(1);
                sh_rd_reg <= (sh_reg - CW'(1) != pos_reg) && sh_rd_reg;
            end
            if (cmd.load_write) count_reg <= count_reg + CW'(1);
            if (cmd.match_commit && (have_lo_reg || have_hi_reg) && win_diff > max_reg)
                max_reg <= win_diff;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
            out_reg <= {ST_LOADED, 10'd0, 32'd0, max_reg};
        else if (cmd.full_result)
            out_reg <= {ST_FULL, 10'd0, 32'd0, max_reg};
        else if (cmd.match_commit)
        begin
            if (have_lo_reg || have_hi_reg)
                out_reg <= {ST_MATCHED,
                            lo_wins ? lo_idx_reg[9:0] : hi_idx_reg[9:0],
                            win_diff,
                            (win_diff > max_reg) ? win_diff : max_reg};
            else
                out_reg <= {ST_EMPTY, 10'd0, 32'd0, max_reg};
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(POOL_DEPTH)) else $error("pool count overflow");
    a_max_mono: assert property (@(posedge clk) disable iff (!rst_n)
        max_reg >= $past(max_reg) || $past(!rst_n)) else $error("running max fell");
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= count_reg) else $error("scan pointer past count");

endmodule

### hdl/nearest_value_match_without_replacement_unit.sv
// nearest_value_match_without_replacement_unit: top level, controller plus datapath
// depends on nvm_pkg, nvm_ctrl, nvm_dpath
//
//   port group    | direction | handshake              | payload
//   in            | input     | in_valid / in_ready    | in_data  (cmd, value)
//   out           | output    | out_valid / out_ready  | out_data (status, index, diffs)
//
// a load scans the sorted pool for its slot (one slot per cycle), then shifts
// the tail up one slot per cycle through the pool memory's read and write ports.
// a query scans live slots until the first at or above the query. a load into
// a full pool goes from the decide state straight to the result. one item is in
// work at a time; the result waits in the output register until taken, and the
// input is ready again in the cycle after the result transfer. reset clears the
// state, count, running max and scan and shift flags, not pool memory or result.
module nearest_value_match_without_replacement_unit #(
    parameter int POOL_DEPTH = nvm_pkg::PoolDepthDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  nvm_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output nvm_pkg::out_item_t out_data
);
    import nvm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    nvm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .cmd(cmd), .stat(stat)
    );

    nvm_dpath #(.POOL_DEPTH(POOL_DEPTH)) u_dpath (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_data), .cmd(cmd), .stat(stat), .out_item(out_data)
    );

endmodule

### tb/testbench.sv
// testbench: randomized regression for nearest_value_match_without_replacement_unit
// depends on nvm_pkg and the unit's rtl; self-checking against an in-file pool predictor
`timescale 1ns / 1ps

module testbench;
    import nvm_pkg::*;

    localparam int DEPTH        = PoolDepthDefault;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 12_000_000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 50;
    localparam int HOLD_CYCLES  = 3000;
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;

    // pool predictor state
    logic [31:0] pool_value [DEPTH];
    logic [9:0]  pool_order [DEPTH];
    logic        pool_live  [DEPTH];
    int          pool_count = 0;
    logic [31:0] worst_diff = '0;

    in_item_t    pending_items [$];
    out_item_t   expected_results [$];
    int          errors = 0;
    int          results_seen = 0;
    longint      cycles = 0;

    nearest_value_match_without_replacement_unit #(
        .POOL_DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #4 clk = ~clk;

    // insert a value after equal ones, or pick the nearest live entry
    function automatic out_item_t match_nearest(in_item_t item);
        out_item_t   res;
        int          pos;
        int          lo;
        int          hi;
        int          win;
        logic [31:0] diff;
        res = '0;
        res.status = ST_LOADED;
        if (item.cmd == CMD_LOAD) begin
            if (pool_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = pool_count;
                for (int k = 0; k < pool_count; k++) begin
                    if (pool_value[k] > item.value) begin
                        pos = k;
                        break;
                    end
                end
                for (int k = pool_count; k > pos; k--) begin
                    pool_value[k] = pool_value[k-1];
                    pool_order[k] = pool_order[k-1];
                    pool_live[k]  = pool_live[k-1];
                end
                pool_value[pos] = item.value;
                pool_order[pos] = pool_count[9:0];
                pool_live[pos]  = 1'b1;
                pool_count++;
            end
        end else begin
            lo = -1;
            hi = -1;
            for (int k = 0; k < pool_count; k++) begin
                if (pool_live[k]) begin
                    if (pool_value[k] < item.value) begin
                        lo = k;
                    end else begin
                        hi = k;
                        break;
                    end
                end
            end
            if (lo < 0 && hi < 0) begin
                res.status = ST_EMPTY;
            end else begin
                if (hi < 0)
                    win = lo;
                else if (lo < 0)
                    win = hi;
                else if ((item.value - pool_value[lo]) < (pool_value[hi] - item.value))
                    win = lo;
                else
                    win = hi;
                diff = (pool_value[win] >= item.value) ? pool_value[win] - item.value
                                                       : item.value - pool_value[win];
                if (diff > worst_diff)
                    worst_diff = diff;
                pool_live[win]    = 1'b0;
                res.status        = ST_MATCHED;
                res.matched_index = pool_order[win];
                res.abs_diff      = diff;
            end
        end
        res.peak_diff = worst_diff;
        return res;
    endfunction

    // values with ties, extremes and clusters
    function automatic logic [31:0] draw_value();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom();
            1: v = $urandom_range(0, 63);
            2: v = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            3: v = 32'h8000_0000 + $urandom_range(0, 15) - 8;
            default: v = {8'($urandom_range(0, 255)), 24'h0} | 32'($urandom_range(0, 3));
        endcase
        return v;
    endfunction

    // sender: one transfer per item, random gap after each, some gap-free stretches
    int  send_gap = 0;
    int  send_count = 0;
    bit  send_burst = 1'b0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(), match_nearest(in_data));
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    send_count++;
                    if (send_count % 97 == 0)
                        send_burst = ~send_burst;
                    send_gap <= send_burst ? 0 : $urandom_range(0, 11);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each transfer, random stall, one long hold-off
    int  take_gap = 0;
    bit  take_burst = 1'b0;
    bit  hold_done = 1'b0;
    always @(posedge clk) begin
        out_item_t exp_res;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with no item pending: %p", out_data);
                    errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (out_data.status !== exp_res.status) begin
                        $error("status exp %0d got %0d", exp_res.status, out_data.status);
                        errors++;
                    end
                    if (out_data.matched_index !== exp_res.matched_index) begin
                        $error("matched_index exp %0d got %0d",
                               exp_res.matched_index, out_data.matched_index);
                        errors++;
                    end
                    if (out_data.abs_diff !== exp_res.abs_diff) begin
                        $error("abs_diff exp %h got %h", exp_res.abs_diff, out_data.abs_diff);
                        errors++;
                    end
                    if (out_data.peak_diff !== exp_res.peak_diff) begin
                        $error("peak_diff exp %h got %h", exp_res.peak_diff,
                               out_data.peak_diff);
                        errors++;
                    end
                end
                if (results_seen % 89 == 0)
                    take_burst = ~take_burst;
                if (results_seen == 300 && !hold_done) begin
                    hold_done = 1'b1;
                    take_gap <= HOLD_CYCLES;
                end else begin
                    take_gap <= take_burst ? 0 : $urandom_range(0, 11);
                end
                out_ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap  <= take_gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("nearest_value_match_without_replacement_unit regression: fail");
            $finish;
        end
    end

    function automatic in_item_t mk(logic cmd, logic [31:0] v);
        in_item_t it;
        it.cmd   = cmd;
        it.value = v;
        return it;
    endfunction

    // append an item to the pending queue
    task automatic queue_item(in_item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty pool, ties, equal distance, nothing below / above, reuse
        queue_item(mk(CMD_QUERY, 32'd7));
        queue_item(mk(CMD_LOAD, 32'd100));
        queue_item(mk(CMD_LOAD, 32'd100));
        queue_item(mk(CMD_LOAD, 32'd0));
        queue_item(mk(CMD_LOAD, 32'hFFFF_FFFF));
        queue_item(mk(CMD_LOAD, 32'd200));
        queue_item(mk(CMD_QUERY, 32'd100));
        queue_item(mk(CMD_QUERY, 32'd150));
        queue_item(mk(CMD_QUERY, 32'd0));
        queue_item(mk(CMD_QUERY, 32'hFFFF_FFFF));
        queue_item(mk(CMD_QUERY, 32'hFFFF_FFFF));
        queue_item(mk(CMD_QUERY, 32'd1));
        queue_item(mk(CMD_LOAD, 32'd3));
        queue_item(mk(CMD_LOAD, 32'h5555_5555));
        queue_item(mk(CMD_LOAD, 32'hAAAA_AAAA));
        queue_item(mk(CMD_QUERY, 32'h8000_0000));
        queue_item(mk(CMD_QUERY, 32'd2));
        queue_item(mk(CMD_QUERY, 32'd2));

        // random: loads dominate so the pool fills and later loads find it full
        for (int n = 0; n < RANDOM_ITEMS; n++)
            queue_item(mk(($urandom_range(0, 99) < 68) ? CMD_LOAD : CMD_QUERY,
                          draw_value()));

        wait (pending_items.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("nearest_value_match_without_replacement_unit regression: pass");
        else
            $display("nearest_value_match_without_replacement_unit regression: fail");
        $finish;
    end

endmodule

### sim.f
hdl/nvm_pkg.sv
hdl/nvm_ctrl.sv
hdl/nvm_dpath.sv
hdl/nearest_value_match_without_replacement_unit.sv
tb/testbench.sv
